[sv/c8x_pkg.sv]
package c8x_pkg;

  localparam int MEMORY_BYTES   = 4096;
  localparam int DISPLAY_WIDTH  = 64;
  localparam int DISPLAY_HEIGHT = 32;

  typedef enum logic [1:0] {
    REQ_EXEC = 2'd0,
    REQ_LOAD = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_WAIT      = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] opcode;
    logic [11:0] mem_address;
    logic [7:0]  mem_data;
    logic [4:0]  display_row;
    logic [15:0] keys_down;
    logic [7:0]  delay_timer_now;
    logic [7:0]  random_byte;
  } item_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [63:0] row_pixels;
    logic        timer_write_valid;
    logic [7:0]  timer_write_value;
    logic [2:0]  status;
  } result_t;

  localparam int unsigned IN_BYTES  = 10;
  localparam int unsigned OUT_BYTES = 11;

endpackage

[sv/c8x_bcd.sv]
module c8x_bcd (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] value,
  output logic       done,
  output logic [3:0] hundreds,
  output logic [3:0] tens,
  output logic [3:0] ones
);
  logic [7:0] rem_r, rem_nxt;
  logic [3:0] h_r, h_nxt, t_r, t_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic       busy_r, busy_nxt;

  always_comb begin
    rem_nxt = rem_r; h_nxt = h_r; t_nxt = t_r; ph_nxt = ph_r; busy_nxt = busy_r;
    if (start) begin
      rem_nxt = value; h_nxt = '0; t_nxt = '0; ph_nxt = 2'd0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ph_r == 2'd0) begin
        if (rem_r >= 8'd100) begin
          rem_nxt = rem_r - 8'd100; h_nxt = h_r + 4'd1;
        end else begin
          ph_nxt = 2'd1;
        end
      end else if (rem_r >= 8'd10) begin
        rem_nxt = rem_r - 8'd10; t_nxt = t_r + 4'd1;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
    end
    rem_r <= rem_nxt;
    h_r   <= h_nxt;
    t_r   <= t_nxt;
  end

  assign done     = busy_r && ph_r == 2'd1 && rem_r < 8'd10;
  assign hundreds = h_r;
  assign tens     = t_r;
  assign ones     = rem_r[3:0];
endmodule

[sv/chip8_instruction_executor.sv]
// CHIP-8 executor: one opcode, memory load or display row read per input
// transaction, one result transaction each; req_type travels on in_tuser.
// A sequencer runs each item through a shared memory port and display port.
// Simple items finish in S_EXEC; a row read goes on through S_ROW, a sprite
// through S_DRAW_RD, S_DRAW_RD2 and S_DRAW_WR for each row, FX55 through
// S_SAVE, FX65 through S_LOAD_RD and S_LOAD_WR for each register, BCD through
// S_BCD (digits counted out by repeated subtraction) and S_BCD_WR, and 00E0
// through S_CLEAR, which clears one display row a cycle. Input is not ready
// while an item runs or its result waits; the next item is taken the cycle
// after the result is accepted. After reset the display is cleared by the
// same row sweep before the first item is taken. Writing cfg loads the pc.
module chip8_instruction_executor #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[15:0], mem_address[27:16], mem_data[35:28], display_row[40:36],
  // keys_down[56:41], delay_timer_now[64:57], random_byte[72:65]
  input  logic [79:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // program_counter[11:0], row_pixels[75:12], timer_write_valid[76],
  // timer_write_value[84:77], status[87:85]
  output logic [87:0] out_tdata
);
  import c8x_pkg::*;

  localparam int AW = $clog2(MEMORY_BYTES);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int XW = $clog2(DISPLAY_WIDTH);
  localparam int YW = $clog2(DISPLAY_HEIGHT);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_DRAW_RD, S_DRAW_RD2, S_DRAW_WR, S_SAVE,
    S_LOAD_RD, S_LOAD_WR, S_BCD, S_BCD_WR, S_ROW, S_OUT
  } state_t;

  state_t state_r;
  logic [7:0]  mem [MEMORY_BYTES];
  logic [DISPLAY_WIDTH-1:0] disp [DISPLAY_HEIGHT];
  logic [11:0] stk [STACK_DEPTH];

  logic [7:0]  v_r [16];
  logic [15:0] i_r;
  logic [11:0] pc_r;
  logic [SPW-1:0] sp_r;
  item_t       it_r;
  result_t     res_r;
  logic        busy_out_r;
  logic        boot_r;
  logic [YW-1:0] clr_r;
  logic [4:0]  cnt_r;
  logic        hit_r;
  logic [7:0]  mrd_r;
  logic [DISPLAY_WIDTH-1:0] drd_r;
  logic [1:0]  dig_r;

  logic [3:0]  ox, oy, on;
  logic [7:0]  nn, vx, vy;
  assign ox = it_r.opcode[11:8];
  assign oy = it_r.opcode[7:4];
  assign on = it_r.opcode[3:0];
  assign nn = it_r.opcode[7:0];
  assign vx = v_r[ox];
  assign vy = v_r[oy];

  item_t in_item;
  assign in_item = item_t'({in_tuser, in_tdata[15:0], in_tdata[27:16],
                            in_tdata[35:28], in_tdata[40:36], in_tdata[56:41],
                            in_tdata[64:57], in_tdata[72:65]});

  logic [AW-1:0] maddr;
  assign maddr = AW'(i_r + {11'd0, cnt_r});
  logic [YW-1:0] drow;
  assign drow = YW'(({8'd0, vy} + {11'd0, cnt_r}) % DISPLAY_HEIGHT);

  logic [DISPLAY_WIDTH-1:0] spr;
  always_comb begin
    spr = '0;
    for (int c = 0; c < 8; c++)
      spr[XW'((vx + c) % DISPLAY_WIDTH)] = mrd_r[7-c];
  end

  logic       bcd_start, bcd_done;
  logic [3:0] bh, bt, bo;
  c8x_bcd u_bcd (
    .clk, .rst_n, .start(bcd_start), .value(vx), .done(bcd_done),
    .hundreds(bh), .tens(bt), .ones(bo)
  );
  assign bcd_start = state_r == S_EXEC && it_r.opcode[15:12] == 4'hF && nn == 8'h33;

  logic [3:0] hikey;
  always_comb begin
    hikey = '0;
    for (int k = 0; k < 16; k++)
      if (it_r.keys_down[k]) hikey = 4'(k);
  end

  logic keyp;
  assign keyp = vx < 8'd16 && it_r.keys_down[vx[3:0]];

  assign in_tready  = state_r == S_IDLE && !busy_out_r;
  assign out_tvalid = busy_out_r;
  assign out_tdata  = {res_r.status, res_r.timer_write_value, res_r.timer_write_valid,
                       res_r.row_pixels, res_r.program_counter};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      busy_out_r <= 1'b0;
      boot_r     <= 1'b1;
      pc_r       <= 12'd512;
      i_r        <= '0;
      sp_r       <= '0;
      for (int k = 0; k < 16; k++) v_r[k] <= '0;
    end else begin
      if (cfg_we) pc_r <= cfg_wdata;
      if (busy_out_r && out_tready) busy_out_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          disp[clr_r] <= '0;
          clr_r <= clr_r + 1'b1;
          if (clr_r == YW'(DISPLAY_HEIGHT - 1)) begin
            boot_r <= 1'b0;
            if (boot_r) state_r <= S_IDLE;
            else state_r <= S_OUT;
          end
        end
        S_IDLE: begin
          if (in_tvalid && !busy_out_r) begin
            it_r  <= in_item;
            res_r <= '0;
            cnt_r <= '0;
            hit_r <= 1'b0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_OUT;
          res_r.status <= ST_DONE;
          case (it_r.req_type)
            REQ_LOAD: mem[AW'(it_r.mem_address)] <= it_r.mem_data;
            REQ_READ: begin
              drd_r <= disp[YW'(it_r.display_row % DISPLAY_HEIGHT)];
              state_r <= S_ROW;
            end
            REQ_EXEC: begin
              pc_r <= pc_r + 12'd2;
              case (it_r.opcode[15:12])
                4'h0: begin
                  if (it_r.opcode == 16'h00E0) begin
                    clr_r <= '0; state_r <= S_CLEAR;
                  end else if (it_r.opcode == 16'h00EE) begin
                    if (sp_r == '0) res_r.status <= ST_UNDERFLOW;
                    else begin
                      sp_r <= sp_r - 1'b1;
                      pc_r <= stk[SW'(sp_r - 1'b1)];
                    end
                  end else res_r.status <= ST_IGNORED;
                end
                4'h1: pc_r <= it_r.opcode[11:0];
                4'h2: begin
                  if (sp_r >= SPW'(STACK_DEPTH)) res_r.status <= ST_OVERFLOW;
                  else begin
                    stk[SW'(sp_r)] <= pc_r + 12'd2;
                    sp_r <= sp_r + 1'b1;
                    pc_r <= it_r.opcode[11:0];
                  end
                end
                4'h3: if (vx == nn) pc_r <= pc_r + 12'd4;
                4'h4: if (vx != nn) pc_r <= pc_r + 12'd4;
                4'h5, 4'h9: begin
                  if (on != 4'h0) res_r.status <= ST_IGNORED;
                  else if ((vx == vy) ^ it_r.opcode[15]) pc_r <= pc_r + 12'd4;
                end
                4'h6: v_r[ox] <= nn;
                4'h7: v_r[ox] <= vx + nn;
                4'h8: begin
                  case (on)
                    4'h0: v_r[ox] <= vy;
                    4'h1: v_r[ox] <= vx | vy;
                    4'h2: v_r[ox] <= vx & vy;
                    4'h3: v_r[ox] <= vx ^ vy;
                    4'h4: begin
                      v_r[ox] <= vx + vy;
                      v_r[15] <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'd255};
                    end
                    4'h5: begin
                      v_r[ox] <= vx - vy; v_r[15] <= {7'd0, vx >= vy};
                    end
                    4'h6: begin
                      v_r[ox] <= vx >> 1; v_r[15] <= {7'd0, vx[0]};
                    end
                    4'h7: begin
                      v_r[ox] <= vy - vx; v_r[15] <= {7'd0, vy >= vx};
                    end
                    4'hE: begin
                      v_r[ox] <= vx << 1; v_r[15] <= {7'd0, vx[7]};
                    end
                    default: res_r.status <= ST_IGNORED;
                  endcase
                end
                4'hA: i_r <= {4'd0, it_r.opcode[11:0]};
                4'hB: pc_r <= it_r.opcode[11:0] + {4'd0, v_r[0]};
                4'hC: v_r[ox] <= it_r.random_byte & nn;
                4'hD: begin
                  if (on == 4'h0) v_r[15] <= '0;
                  else state_r <= S_DRAW_RD;
                end
                4'hE: begin
                  if (nn == 8'h9E) begin
                    if (keyp) pc_r <= pc_r + 12'd4;
                  end else if (nn == 8'hA1) begin
                    if (!keyp) pc_r <= pc_r + 12'd4;
                  end else res_r.status <= ST_IGNORED;
                end
                default: begin
                  case (nn)
                    8'h07: v_r[ox] <= it_r.delay_timer_now;
                    8'h0A: begin
                      if (it_r.keys_down == '0) begin
                        pc_r <= pc_r; res_r.status <= ST_WAIT;
                      end else v_r[ox] <= {4'd0, hikey};
                    end
                    8'h15: begin
                      res_r.timer_write_valid <= 1'b1;
                      res_r.timer_write_value <= vx;
                    end
                    8'h18: ;
                    8'h1E: i_r <= i_r + {8'd0, vx};
                    8'h29: i_r <= {8'd0, vx} * 16'd5;
                    8'h33: begin dig_r <= '0; state_r <= S_BCD; end
                    8'h55: state_r <= S_SAVE;
                    8'h65: state_r <= S_LOAD_RD;
                    default: res_r.status <= ST_IGNORED;
                  endcase
                end
              endcase
            end
            default: res_r.status <= ST_IGNORED;
          endcase
        end
        S_DRAW_RD: begin
          mrd_r <= mem[maddr];
          state_r <= S_DRAW_RD2;
        end
        S_DRAW_RD2: begin
          drd_r <= disp[drow];
          state_r <= S_DRAW_WR;
        end
        S_DRAW_WR: begin
          disp[drow] <= drd_r ^ spr;
          if ((drd_r & spr) != '0) hit_r <= 1'b1;
          if (cnt_r == {1'b0, on} - 5'd1) begin
            v_r[15] <= {7'd0, hit_r || (drd_r & spr) != '0};
            state_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
            state_r <= S_DRAW_RD;
          end
        end
        S_SAVE: begin
          mem[maddr] <= v_r[cnt_r[3:0]];
          if (cnt_r[3:0] == ox) begin
            i_r <= i_r + {12'd0, ox} + 16'd1;
            state_r <= S_OUT;
          end else cnt_r <= cnt_r + 5'd1;
        end
        S_LOAD_RD: begin
          mrd_r <= mem[maddr];
          state_r <= S_LOAD_WR;
        end
        S_LOAD_WR: begin
          v_r[cnt_r[3:0]] <= mrd_r;
          if (cnt_r[3:0] == ox) begin
            i_r <= i_r + {12'd0, ox} + 16'd1;
            state_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
            state_r <= S_LOAD_RD;
          end
        end
        S_BCD: if (bcd_done) state_r <= S_BCD_WR;
        S_BCD_WR: begin
          mem[maddr] <= {4'd0, dig_r == 2'd0 ? bh : (dig_r == 2'd1 ? bt : bo)};
          dig_r <= dig_r + 2'd1;
          cnt_r <= cnt_r + 5'd1;
          if (dig_r == 2'd2) state_r <= S_OUT;
        end
        S_ROW: begin
          res_r.row_pixels <= 64'(drd_r);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!busy_out_r) begin
            res_r.program_counter <= pc_r;
            busy_out_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE && !out_tvalid) else $error("ready while busy");
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH)) else $error("stack pointer out of range");
  a_no_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("overlap");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while waiting");
`endif
endmodule

[tb/sv/chip8_instruction_executor_tb.sv]
`timescale 1ns / 100ps

module chip8_instruction_executor_tb;
  import c8x_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [11:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;

  chip8_instruction_executor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // cpu shadow state
  logic [7:0]  vreg [16];
  logic [15:0] ireg;
  logic [11:0] pc_q;
  logic [11:0] ret_stack [16];
  int          sp_q;
  logic [7:0]  mem_q [4096];
  bit          mem_known [4096];
  logic [63:0] screen [32];

  item_t   send_q[$];
  result_t result_q[$];
  int      errors = 0;
  int      idle_cycles = 0;
  bit      gaps_on = 1'b1;
  int      in_gap = 0;
  int      out_stall = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void skip_when(bit c);
    if (c) pc_q = pc_q + 12'd2;
  endfunction

  function automatic bit key_is_down(logic [15:0] keys, logic [7:0] k);
    if (k >= 8'd16) return 1'b0;
    return keys[k[3:0]];
  endfunction

  function automatic void store_byte(logic [15:0] addr, logic [7:0] val);
    mem_q[addr[11:0]] = val;
    mem_known[addr[11:0]] = 1'b1;
  endfunction

  function automatic status_t run_alu(int x, int y, logic [3:0] sub);
    logic [7:0] a, b, flag;
    a = vreg[x];
    b = vreg[y];
    case (sub)
      4'h0: begin vreg[x] = b; return ST_DONE; end
      4'h1: begin vreg[x] = a | b; return ST_DONE; end
      4'h2: begin vreg[x] = a & b; return ST_DONE; end
      4'h3: begin vreg[x] = a ^ b; return ST_DONE; end
      4'h4: begin flag = {7'd0, ({1'b0, a} + {1'b0, b}) > 9'd255}; vreg[x] = a + b; end
      4'h5: begin flag = {7'd0, a >= b}; vreg[x] = a - b; end
      4'h6: begin flag = {7'd0, a[0]}; vreg[x] = a >> 1; end
      4'h7: begin flag = {7'd0, b >= a}; vreg[x] = b - a; end
      4'hE: begin flag = {7'd0, a[7]}; vreg[x] = a << 1; end
      default: return ST_IGNORED;
    endcase
    vreg[15] = flag;
    return ST_DONE;
  endfunction

  function automatic status_t run_opcode(item_t it, inout result_t r);
    logic [15:0] op;
    int x, y, n, k, row_y, col;
    logic [7:0] nn, bits, hit;
    logic [11:0] nnn, old_pc;
    op = it.opcode;
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    nn = op[7:0];
    nnn = op[11:0];
    old_pc = pc_q;
    pc_q = pc_q + 12'd2;
    case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) begin
          for (k = 0; k < 32; k++) screen[k] = '0;
          return ST_DONE;
        end
        if (op == 16'h00EE) begin
          if (sp_q == 0) return ST_UNDERFLOW;
          sp_q--;
          pc_q = ret_stack[sp_q];
          return ST_DONE;
        end
        return ST_IGNORED;
      end
      4'h1: begin pc_q = nnn; return ST_DONE; end
      4'h2: begin
        if (sp_q >= 16) return ST_OVERFLOW;
        ret_stack[sp_q] = pc_q;
        sp_q++;
        pc_q = nnn;
        return ST_DONE;
      end
      4'h3: begin skip_when(vreg[x] == nn); return ST_DONE; end
      4'h4: begin skip_when(vreg[x] != nn); return ST_DONE; end
      4'h5: begin
        if (n != 0) return ST_IGNORED;
        skip_when(vreg[x] == vreg[y]);
        return ST_DONE;
      end
      4'h6: begin vreg[x] = nn; return ST_DONE; end
      4'h7: begin vreg[x] = vreg[x] + nn; return ST_DONE; end
      4'h8: return run_alu(x, y, op[3:0]);
      4'h9: begin
        if (n != 0) return ST_IGNORED;
        skip_when(vreg[x] != vreg[y]);
        return ST_DONE;
      end
      4'hA: begin ireg = {4'h0, nnn}; return ST_DONE; end
      4'hB: begin pc_q = nnn + {4'h0, vreg[0]}; return ST_DONE; end
      4'hC: begin vreg[x] = it.random_byte & nn; return ST_DONE; end
      4'hD: begin
        hit = 8'd0;
        for (k = 0; k < n; k++) begin
          bits = mem_q[(ireg + 16'(k)) & 16'h0FFF];
          row_y = (vreg[y] + k) % 32;
          for (int c = 0; c < 8; c++) begin
            if (bits[7 - c]) begin
              col = (vreg[x] + c) % 64;
              if (screen[row_y][col]) hit = 8'd1;
              screen[row_y][col] = ~screen[row_y][col];
            end
          end
        end
        vreg[15] = hit;
        return ST_DONE;
      end
      4'hE: begin
        if (nn == 8'h9E) begin
          skip_when(key_is_down(it.keys_down, vreg[x]));
          return ST_DONE;
        end
        if (nn == 8'hA1) begin
          skip_when(!key_is_down(it.keys_down, vreg[x]));
          return ST_DONE;
        end
        return ST_IGNORED;
      end
      default: ;
    endcase
    case (nn)
      8'h07: begin vreg[x] = it.delay_timer_now; return ST_DONE; end
      8'h0A: begin
        if (it.keys_down == 16'd0) begin
          pc_q = old_pc;
          return ST_WAIT;
        end
        for (k = 0; k < 16; k++) if (it.keys_down[k]) vreg[x] = 8'(k);
        return ST_DONE;
      end
      8'h15: begin
        r.timer_write_valid = 1'b1;
        r.timer_write_value = vreg[x];
        return ST_DONE;
      end
      8'h18: return ST_DONE;
      8'h1E: begin ireg = ireg + {8'h0, vreg[x]}; return ST_DONE; end
      8'h29: begin ireg = 16'(vreg[x] * 5); return ST_DONE; end
      8'h33: begin
        store_byte(ireg, 8'(vreg[x] / 100));
        store_byte(ireg + 16'd1, 8'((vreg[x] / 10) % 10));
        store_byte(ireg + 16'd2, 8'(vreg[x] % 10));
        return ST_DONE;
      end
      8'h55: begin
        for (k = 0; k <= x; k++) store_byte(ireg + 16'(k), vreg[k]);
        ireg = ireg + 16'(x + 1);
        return ST_DONE;
      end
      8'h65: begin
        for (k = 0; k <= x; k++) vreg[k] = mem_q[(ireg + 16'(k)) & 16'h0FFF];
        ireg = ireg + 16'(x + 1);
        return ST_DONE;
      end
      default: return ST_IGNORED;
    endcase
  endfunction

  function automatic result_t predict_item(item_t it);
    result_t r;
    status_t st;
    r = '0;
    case (req_t'(it.req_type))
      REQ_EXEC: begin
        st = run_opcode(it, r);
        r.status = st;
      end
      REQ_LOAD: store_byte({4'h0, it.mem_address}, it.mem_data);
      REQ_READ: r.row_pixels = screen[it.display_row];
      default:  r.status = ST_IGNORED;
    endcase
    r.program_counter = pc_q;
    return r;
  endfunction

  function automatic item_t rand_fields();
    item_t it;
    it = '0;
    it.req_type        = REQ_EXEC;
    it.opcode          = 16'($urandom());
    it.mem_address     = 12'($urandom());
    it.mem_data        = 8'($urandom());
    it.display_row     = 5'($urandom());
    it.keys_down       = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom());
    it.delay_timer_now = 8'($urandom());
    it.random_byte     = 8'($urandom());
    return it;
  endfunction

  function automatic void queue_item(item_t it);
    send_q.insert(send_q.size(), it);
    result_q.insert(result_q.size(), predict_item(it));
  endfunction

  // sprite and register-load opcodes must not touch unwritten memory
  function automatic void queue_with_fill(item_t it);
    int cnt;
    logic [11:0] a;
    item_t ld;
    cnt = 0;
    if (it.req_type == REQ_EXEC) begin
      if (it.opcode[15:12] == 4'hD) cnt = it.opcode[3:0];
      else if (it.opcode[15:12] == 4'hF && it.opcode[7:0] == 8'h65)
        cnt = it.opcode[11:8] + 1;
    end
    for (int k = 0; k < cnt; k++) begin
      a = 12'(ireg + 16'(k));
      if (!mem_known[a]) begin
        ld = rand_fields();
        ld.req_type = REQ_LOAD;
        ld.mem_address = a;
        queue_item(ld);
      end
    end
    queue_item(it);
  endfunction

  function automatic void queue_op(logic [15:0] op, logic [15:0] keys);
    item_t it;
    it = rand_fields();
    it.opcode = op;
    it.keys_down = keys;
    queue_with_fill(it);
  endfunction

  function automatic logic [15:0] random_opcode();
    logic [3:0] x, y;
    logic [7:0] fx_nn [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33,
                              8'h55, 8'h65};
    logic [3:0] alu_sub [9] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
                                4'hE};
    x = 4'($urandom());
    y = 4'($urandom());
    case ($urandom_range(0, 15))
      0:  return 16'h00E0;
      1:  return 16'h00EE;
      2:  return {4'h2, 12'($urandom())};
      3:  return {4'h8, x, y, alu_sub[$urandom_range(0, 8)]};
      4:  return {4'hF, x, fx_nn[$urandom_range(0, 8)]};
      5:  return {4'hD, x, y, 4'($urandom())};
      6:  return {4'hE, x, ($urandom_range(0, 1) != 0) ? 8'h9E : 8'hA1};
      7:  return {4'h6, x, 8'($urandom())};
      8:  return {4'hA, 12'($urandom())};
      9:  return {4'h3 + 4'($urandom_range(0, 6)), x, y, 4'h0};
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic settle_and_config(logic [11:0] val);
    wait (send_q.size() == 0 && result_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    pc_q = val;
  endtask

  task automatic random_phase(int count);
    item_t it;
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 2) begin
        for (int k = 0; k < 18; k++) queue_op({4'h2, 12'($urandom())}, 16'($urandom()));
        for (int k = 0; k < 18; k++) queue_op(16'h00EE, 16'($urandom()));
      end else if (kind < 10) begin
        it = rand_fields();
        it.req_type = REQ_LOAD;
        queue_item(it);
      end else if (kind < 18) begin
        it = rand_fields();
        it.req_type = REQ_READ;
        queue_item(it);
      end else if (kind < 20) begin
        it = rand_fields();
        it.req_type = REQ_NONE;
        queue_item(it);
      end else begin
        it = rand_fields();
        it.opcode = random_opcode();
        queue_with_fill(it);
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (send_q.size() > 0) begin
        item_t it;
        it = send_q.pop_front();
        in_tuser <= it.req_type;
        in_tdata <= {7'd0, it.random_byte, it.delay_timer_now, it.keys_down,
                     it.display_row, it.mem_data, it.mem_address, it.opcode};
        in_tvalid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_stall <= pick_gap();
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, out_tdata);
          errors <= errors + 1;
        end else begin
          result_t e;
          e = result_q.pop_front();
          if (out_tdata[11:0] !== e.program_counter ||
              out_tdata[75:12] !== e.row_pixels ||
              out_tdata[76] !== e.timer_write_valid ||
              out_tdata[84:77] !== e.timer_write_value ||
              out_tdata[87:85] !== e.status) begin
            $display("%0t: mismatch expected pc=%h row=%h tv=%b tval=%h st=%0d",
                     $time, e.program_counter, e.row_pixels, e.timer_write_valid,
                     e.timer_write_value, e.status);
            $display("%0t:          actual   pc=%h row=%h tv=%b tval=%h st=%0d",
                     $time, out_tdata[11:0], out_tdata[75:12], out_tdata[76],
                     out_tdata[84:77], out_tdata[87:85]);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("chip8_instruction_executor_tb: FAIL");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < 16; k++) begin vreg[k] = '0; ret_stack[k] = '0; end
    for (int k = 0; k < 4096; k++) begin mem_q[k] = '0; mem_known[k] = 1'b0; end
    for (int k = 0; k < 32; k++) screen[k] = '0;
    ireg = '0;
    pc_q = 12'd512;
    sp_q = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed corner cases
    queue_op(16'h00EE, 16'h0001);
    queue_op(16'h00E0, 16'h0000);
    queue_op(16'h60FF, 16'h0000);
    queue_op(16'h6F01, 16'h0000);
    queue_op(16'h8F04, 16'h0000);
    queue_op(16'h8F0E, 16'h0000);
    queue_op(16'h80F6, 16'h0000);
    queue_op(16'h8128, 16'h0000);
    queue_op(16'h5121, 16'h0000);
    queue_op(16'hF00A, 16'h0000);
    queue_op(16'hF30A, 16'hFFFF);
    queue_op(16'hF015, 16'h0000);
    queue_op(16'hF018, 16'h0000);
    queue_op(16'hF207, 16'h0000);
    queue_op(16'hC5FF, 16'h0000);
    queue_op(16'hE09E, 16'hFFFF);
    queue_op(16'hAFFF, 16'h0000);
    queue_op(16'hF033, 16'h0000);
    queue_op(16'h613C, 16'h0000);
    queue_op(16'h621E, 16'h0000);
    queue_op(16'hD12F, 16'h0000);
    queue_op(16'hD120, 16'h0000);
    queue_op(16'hFF65, 16'h0000);
    queue_op(16'hBFFF, 16'h0000);
    begin
      item_t it;
      it = rand_fields();
      it.req_type = REQ_READ;
      it.display_row = 5'd31;
      queue_item(it);
    end

    settle_and_config(12'd0);
    random_phase(200);
    settle_and_config(12'hFFF);
    random_phase(200);
    gaps_on = 1'b0;
    settle_and_config(12'($urandom()));
    random_phase(160);
    gaps_on = 1'b1;
    settle_and_config(12'd512);
    random_phase(200);

    wait (send_q.size() == 0 && result_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("chip8_instruction_executor_tb: PASS");
    end else begin
      $display("chip8_instruction_executor_tb: FAIL");
    end
    $finish;
  end

endmodule
